// ===== rtl/bto_pkg.sv =====
// Shared constants and register codes for the box/triangle overlap block.
package bto_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int LIMB_WIDTH      = 16;
    localparam int CFG_ADDR_W      = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_HALF_X   = 3'd3,
        REG_HALF_Y   = 3'd4,
        REG_HALF_Z   = 3'd5
    } reg_idx_t;

endpackage

// ===== rtl/bto_mulcell.sv =====
// One cell of the multiplier row: multiply by one limb of B and accumulate.
module bto_mulcell #(
    parameter int AW   = 25,
    parameter int BPW  = 64,
    parameter int PW   = 80,
    parameter int LIMB = 16,
    parameter int IDX  = 0,
    parameter bit TOP  = 1'b0
) (
    input  logic                  clk,
    input  logic                  ce,
    input  logic signed [AW-1:0]  a_in,
    input  logic        [BPW-1:0] b_in,
    input  logic signed [PW-1:0]  acc_in,
    output logic signed [AW-1:0]  a_out,
    output logic        [BPW-1:0] b_out,
    output logic signed [PW-1:0]  acc_out
);
    logic        [LIMB-1:0]      limb;
    logic                        ext;
    logic signed [AW+LIMB:0]     prod;
    logic signed [PW-1:0]        term;
    logic signed [AW-1:0]        a_reg;
    logic        [BPW-1:0]       b_reg;
    logic signed [PW-1:0]        acc_reg;

    assign limb = b_in[IDX*LIMB +: LIMB];
    // only the top limb carries the sign of B
    assign ext  = TOP ? limb[LIMB-1] : 1'b0;
    assign prod = a_in * $signed({ext, limb});
    assign term = PW'(prod) <<< (IDX*LIMB);

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            a_reg   <= a_in;
            b_reg   <= b_in;
            acc_reg <= acc_in + term;
        end
    end

    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign acc_out = acc_reg;
endmodule

// ===== rtl/bto_mulrow.sv =====
// Row of multiplier cells: signed A times wide signed B, one limb per cell.
module bto_mulrow #(
    parameter int AW   = 25,
    parameter int BW   = 54,
    parameter int LIMB = 16
) (
    input  logic                     clk,
    input  logic                     ce,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]  p
);
    localparam int NL  = (BW + LIMB - 1) / LIMB;
    localparam int BPW = NL * LIMB;
    localparam int PW  = AW + BW;

    logic signed [AW-1:0]  a_c   [NL+1];
    logic        [BPW-1:0] b_c   [NL+1];
    logic signed [PW-1:0]  acc_c [NL+1];

    assign a_c[0]   = a;
    assign b_c[0]   = BPW'(b);
    assign acc_c[0] = '0;

    for (genvar k = 0; k < NL; k++)
    begin : g_cell
        bto_mulcell #(
            .AW   (AW),
            .BPW  (BPW),
            .PW   (PW),
            .LIMB (LIMB),
            .IDX  (k),
            .TOP  (k == NL - 1)
        ) u_cell (
            .clk     (clk),
            .ce      (ce),
            .a_in    (a_c[k]),
            .b_in    (b_c[k]),
            .acc_in  (acc_c[k]),
            .a_out   (a_c[k+1]),
            .b_out   (b_c[k+1]),
            .acc_out (acc_c[k+1])
        );
    end

    assign p = acc_c[NL];
endmodule

// ===== rtl/box_triangle_overlap_sat.sv =====
// Top level: box versus triangle overlap by separating-axis test.
//
//  channel  | signals                       | contents
//  ---------+-------------------------------+-------------------------------------
//  input    | s_tvalid s_tready s_tdata     | one triangle (nine vertex coords)
//  output   | m_tvalid m_tready m_tdata     | overlap flag in bit 0
//  config   | cfg_we cfg_addr cfg_wdata     | box center and half extents
//
// One triangle per cycle while the pipeline is not held. NL is the number of
// limb cells in the multiplier rows that form the triangle-normal projection
// (NL = ceil((2*COORD_WIDTH+6)/16), 4 at the default width).
// Reset clears the box registers and all beat valid flags.
// The pipeline holds only when a result sits in the output register, the
// sink does not take it and another result is ready to land behind it.
module box_triangle_overlap_sat #(
    parameter int COORD_WIDTH = bto_pkg::COORD_WIDTH_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    // vert0_x, vert0_y, vert0_z, vert1_x, ... vert2_z from bit 0 up
    input  logic [8*((9*COORD_WIDTH+7)/8)-1:0]         s_tdata,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    // overlap in bit 0, zeros above
    output logic [7:0]                                 m_tdata,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    input  logic                                       cfg_we,
    input  logic [bto_pkg::CFG_ADDR_W-1:0]             cfg_addr,
    input  logic [COORD_WIDTH-1:0]                     cfg_wdata
);
    import bto_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int HW  = W - 1;            // half extent width
    localparam int VW  = W + 1;            // box-local vertex
    localparam int EW  = W + 2;            // edge
    localparam int NW  = 2*EW + 1;         // normal component
    localparam int AN  = NW + 1;           // normal component, room for abs
    localparam int NL  = (AN + LIMB_WIDTH - 1) / LIMB_WIDTH;
    localparam int PW  = VW + AN;          // one normal-axis product
    localparam int SW  = PW + 2;           // sum of three products
    localparam int EPW = VW + EW;          // edge-axis product
    localparam int ERW = HW + EW;          // edge-axis radius term
    localparam int ECW = EPW + 2;          // edge-axis compare width
    localparam int BCW = VW + 1;           // box-axis compare width

    // box registers
    logic signed [W-1:0]  ctr_reg  [3];
    logic        [HW-1:0] half_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ctr_reg[k]  <= '0;
                half_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_CENTER_X: ctr_reg[0]  <= cfg_wdata;
                REG_CENTER_Y: ctr_reg[1]  <= cfg_wdata;
                REG_CENTER_Z: ctr_reg[2]  <= cfg_wdata;
                REG_HALF_X:   half_reg[0] <= cfg_wdata[HW-1:0];
                REG_HALF_Y:   half_reg[1] <= cfg_wdata[HW-1:0];
                REG_HALF_Z:   half_reg[2] <= cfg_wdata[HW-1:0];
                default:      ;
            endcase
        end
    end

    // pipeline advance
    logic ce;
    logic accept;
    logic out_valid_reg;
    logic out_overlap_reg;
    logic tail_vld_reg [NL+1];
    logic tail_sep_reg [NL+1];

    // advance unless a new result would land on one the sink has not taken
    assign ce       = !(out_valid_reg && !m_tready && tail_vld_reg[NL]);
    assign s_tready = ce;
    assign accept   = s_tvalid && ce;

    // stage 1: move vertices into box-local space
    logic               s1_vld_reg;
    logic signed [VW-1:0] s1_v_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    s1_v_reg[i][j] <= VW'($signed(s_tdata[(3*i+j)*W +: W]))
                                    - VW'(ctr_reg[j]);
                end
            end
        end
    end

    // stage 2: form edges
    logic                 s2_vld_reg;
    logic signed [VW-1:0] s2_v_reg [3][3];
    logic signed [EW-1:0] s2_e_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    s2_v_reg[i][j] <= s1_v_reg[i][j];
                    s2_e_reg[i][j] <= EW'(s1_v_reg[(i+1)%3][j]) - EW'(s1_v_reg[i][j]);
                end
            end
        end
    end

    // box axes: separated when all three vertices lie beyond +half, or all beyond -half
    logic [2:0] box_sep;

    for (genvar j = 0; j < 3; j++)
    begin : g_box
        logic signed [BCW-1:0] hp, hn;
        logic signed [BCW-1:0] c0, c1, c2;
        assign hp = $signed(BCW'(half_reg[j]));
        assign hn = -hp;
        assign c0 = BCW'(s2_v_reg[0][j]);
        assign c1 = BCW'(s2_v_reg[1][j]);
        assign c2 = BCW'(s2_v_reg[2][j]);
        assign box_sep[j] = (c0 > hp && c1 > hp && c2 > hp)
                         || (c0 < hn && c1 < hn && c2 < hn);
    end

    // stage 3: edge-axis products and normal products
    logic                  s3_vld_reg;
    logic                  s3_sep_reg;
    logic signed [VW-1:0]  s3_v0_reg [3];
    // edge i times box axis j; vertex i and vertex i+2 (vertex i+1 repeats i)
    logic signed [EPW-1:0] s3_pm_reg [3][3][2];
    logic signed [EPW-1:0] s3_pn_reg [3][3][2];
    logic        [ERW-1:0] s3_ra_reg [3][3];
    logic        [ERW-1:0] s3_rb_reg [3][3];
    logic signed [2*EW-1:0] s3_np_reg [3][2];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s3_sep_reg <= |box_sep;
            for (int k = 0; k < 3; k++)
            begin
                s3_v0_reg[k]    <= s2_v_reg[0][k];
                s3_np_reg[k][0] <= s2_e_reg[0][(k+1)%3] * s2_e_reg[1][(k+2)%3];
                s3_np_reg[k][1] <= s2_e_reg[0][(k+2)%3] * s2_e_reg[1][(k+1)%3];
            end
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_edge
        for (genvar j = 0; j < 3; j++)
        begin : g_axis
            localparam int M = (j + 1) % 3;
            localparam int N = (j + 2) % 3;
            logic [EW-1:0] abs_em, abs_en;
            assign abs_em = s2_e_reg[i][M][EW-1] ? EW'(-s2_e_reg[i][M]) : EW'(s2_e_reg[i][M]);
            assign abs_en = s2_e_reg[i][N][EW-1] ? EW'(-s2_e_reg[i][N]) : EW'(s2_e_reg[i][N]);

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    s3_pm_reg[i][j][0] <= s2_v_reg[i][M] * s2_e_reg[i][N];
                    s3_pn_reg[i][j][0] <= s2_v_reg[i][N] * s2_e_reg[i][M];
                    s3_pm_reg[i][j][1] <= s2_v_reg[(i+2)%3][M] * s2_e_reg[i][N];
                    s3_pn_reg[i][j][1] <= s2_v_reg[(i+2)%3][N] * s2_e_reg[i][M];
                    s3_ra_reg[i][j]    <= half_reg[M] * abs_en;
                    s3_rb_reg[i][j]    <= half_reg[N] * abs_em;
                end
            end
        end
    end

    // edge-axis compare
    logic [8:0] edge_sep;

    for (genvar i = 0; i < 3; i++)
    begin : g_ecmp
        for (genvar j = 0; j < 3; j++)
        begin : g_axis
            logic signed [ECW-1:0] p0, p1, rp, rn;
            assign p0 = ECW'(s3_pm_reg[i][j][0]) - ECW'(s3_pn_reg[i][j][0]);
            assign p1 = ECW'(s3_pm_reg[i][j][1]) - ECW'(s3_pn_reg[i][j][1]);
            assign rp = $signed(ECW'(s3_ra_reg[i][j]) + ECW'(s3_rb_reg[i][j]));
            assign rn = -rp;
            assign edge_sep[3*i+j] = (p0 > rp && p1 > rp) || (p0 < rn && p1 < rn);
        end
    end

    // stage 4: triangle normal
    logic                 s4_vld_reg;
    logic                 s4_sep_reg;
    logic signed [VW-1:0] s4_v0_reg [3];
    logic signed [NW-1:0] s4_n_reg  [3];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s4_sep_reg <= s3_sep_reg | (|edge_sep);
            for (int k = 0; k < 3; k++)
            begin
                s4_v0_reg[k] <= s3_v0_reg[k];
                s4_n_reg[k]  <= NW'(s3_np_reg[k][0]) - NW'(s3_np_reg[k][1]);
            end
        end
    end

    // normal axis: all three projections are equal, so one dot product does
    logic signed [PW-1:0] prj   [3];
    logic signed [PW-1:0] rad   [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_nrm
        logic signed [AN-1:0] n_ext, n_abs;
        assign n_ext = AN'(s4_n_reg[k]);
        assign n_abs = n_ext[AN-1] ? -n_ext : n_ext;

        bto_mulrow #(.AW(VW), .BW(AN), .LIMB(LIMB_WIDTH)) u_prj (
            .clk (clk),
            .ce  (ce),
            .a   (s4_v0_reg[k]),
            .b   (n_ext),
            .p   (prj[k])
        );

        bto_mulrow #(.AW(VW), .BW(AN), .LIMB(LIMB_WIDTH)) u_rad (
            .clk (clk),
            .ce  (ce),
            .a   ($signed(VW'(half_reg[k]))),
            .b   (n_abs),
            .p   (rad[k])
        );
    end

    // sum stage, timed with the last tail slot
    logic signed [SW-1:0] ps_reg, rs_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            ps_reg <= SW'(prj[0]) + SW'(prj[1]) + SW'(prj[2]);
            rs_reg <= SW'(rad[0]) + SW'(rad[1]) + SW'(rad[2]);
        end
    end

    // tail flags follow the beat through the multiplier rows
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            tail_sep_reg[0] <= s4_sep_reg;
            for (int k = 1; k <= NL; k++)
            begin
                tail_sep_reg[k] <= tail_sep_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            for (int k = 0; k <= NL; k++)
            begin
                tail_vld_reg[k] <= 1'b0;
            end
        end
        else if (ce)
        begin
            s1_vld_reg      <= accept;
            s2_vld_reg      <= s1_vld_reg;
            s3_vld_reg      <= s2_vld_reg;
            s4_vld_reg      <= s3_vld_reg;
            tail_vld_reg[0] <= s4_vld_reg;
            for (int k = 1; k <= NL; k++)
            begin
                tail_vld_reg[k] <= tail_vld_reg[k-1];
            end
        end
    end

    // final decision and output register
    logic nrm_sep;
    assign nrm_sep = (ps_reg > rs_reg) || (ps_reg < -rs_reg);

    always_ff @(posedge clk)
    begin
        if (ce && tail_vld_reg[NL])
        begin
            out_overlap_reg <= !(tail_sep_reg[NL] || nrm_sep);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce && tail_vld_reg[NL])
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_overlap_reg};
endmodule

// ===== rtl/bto_check.sv =====
// Port-level checks for the overlap block, bound to the top level.
module bto_check (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] m_tdata,
    input logic       m_tvalid,
    input logic       m_tready
);
    // a held result stays put until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // input stalls only behind a blocked output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // padding bits of the result stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:1] == 7'b0)
        else $error("result padding not zero");

    // nothing comes out in the cycle right after reset ends
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result shown right after reset");
endmodule

bind box_triangle_overlap_sat bto_check u_bto_check (.*);

// ===== tb/sv/tb_top.sv =====
// Testbench for box_triangle_overlap_sat: directed and random triangles checked per beat.
module tb_top;
    import bto_pkg::*;

    localparam int CW        = 24;
    localparam int TDATA_W   = 8 * ((9 * CW + 7) / 8);
    // Settle time once the queue is empty, longer than the pipeline takes to flush (NL = 4 at 24 bits).
    localparam int SETTLE    = 30;
    localparam int CYCLE_CAP = 400000;
    // Addresses past the last box register; writes there must be dropped.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

    typedef logic signed [127:0] wide_t;
    typedef int tri_t [9];   // vert0_x .. vert2_z

    logic                  clk;
    logic                  rst_n;
    logic [TDATA_W-1:0]    s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CW-1:0]         cfg_wdata;

    // Shadow copy of the box registers.
    logic [CW-1:0]   box_ctr [3];
    logic [CW-2:0]   box_half [3];

    bit              overlap_q [$];
    int              err_cnt;
    int              cyc_cnt;
    int              src_idle_pct;
    int              sink_idle_pct;
    int              sink_holdoff;

    box_triangle_overlap_sat #(.COORD_WIDTH(CW)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic wide_t sext(logic [CW-1:0] raw);
        wide_t w;
        w = {{(128 - CW){raw[CW-1]}}, raw};
        return w;
    endfunction

    // Exact separating-axis test on the shadow box; 1 = overlap.
    function automatic bit overlap_of(tri_t t);
        wide_t v [3][3];
        wide_t e [3][3];
        wide_t ax [13][3];
        wide_t h [3];
        wide_t a [3];
        wide_t b [3];
        wide_t p, lo, hi, r;
        int n;
        n = 0;
        for (int k = 0; k < 3; k++)
            h[k] = {{(129 - CW){1'b0}}, box_half[k]};
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                v[i][k] = sext(t[3 * i + k][CW-1:0]) - sext(box_ctr[k]);
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
                e[i][k] = v[(i + 1) % 3][k] - v[i][k];
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
                ax[n][k] = (k == j) ? 1 : 0;
            n++;
        end
        // Edge-by-box-axis crosses, then the face normal e0 x e1.
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (i == 3 && j > 0)
                    break;
                for (int k = 0; k < 3; k++)
                begin
                    a[k] = (i == 3) ? e[0][k] : e[i][k];
                    b[k] = (i == 3) ? e[1][k] : ((k == j) ? 1 : 0);
                end
                for (int k = 0; k < 3; k++)
                    ax[n][k] = a[(k + 1) % 3] * b[(k + 2) % 3]
                             - a[(k + 2) % 3] * b[(k + 1) % 3];
                n++;
            end
        end
        for (int x = 0; x < 13; x++)
        begin
            r = 0;
            for (int k = 0; k < 3; k++)
                r += h[k] * ((ax[x][k] < 0) ? -ax[x][k] : ax[x][k]);
            for (int i = 0; i < 3; i++)
            begin
                p = v[i][0] * ax[x][0] + v[i][1] * ax[x][1] + v[i][2] * ax[x][2];
                if (i == 0 || p < lo) lo = (i == 0) ? p : p;
                if (i == 0) hi = p;
                else if (p > hi) hi = p;
            end
            if (r < lo || hi < -r)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Sink side: random stalls, plus a long hold-off counted here.
    always @(negedge clk)
    begin
        if (sink_holdoff > 0)
        begin
            sink_holdoff <= sink_holdoff - 1;
            m_tready     <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Compare each accepted result beat against the oldest expected flag.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (overlap_q.size() == 0)
            begin
                $display("%0t: unexpected result beat, actual overlap=%0b", $time, m_tdata[0]);
                err_cnt++;
            end
            else
            begin
                bit exp_ov;
                exp_ov = overlap_q.pop_front();
                if (m_tdata[0] !== exp_ov)
                begin
                    $display("%0t: overlap mismatch, expected %0b actual %0b",
                             $time, exp_ov, m_tdata[0]);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cyc_cnt++;
        if (cyc_cnt > CYCLE_CAP)
        begin
            $display("FAIL box_triangle_overlap_sat");
            $finish;
        end
    end

    // Called at a falling edge; returns at a falling edge.
    task automatic send_triangle(tri_t t);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        for (int i = 0; i < 9; i++)
            s_tdata[CW * i +: CW] = t[i][CW-1:0];
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        overlap_q.push_back(overlap_of(t));
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Block is idle only when nothing is pending and the pipeline has flushed.
    task automatic drain();
        while (overlap_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CW-1:0] val);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        case (idx)
            REG_CENTER_X: box_ctr[0]  = val;
            REG_CENTER_Y: box_ctr[1]  = val;
            REG_CENTER_Z: box_ctr[2]  = val;
            REG_HALF_X:   box_half[0] = val[CW-2:0];
            REG_HALF_Y:   box_half[1] = val[CW-2:0];
            REG_HALF_Z:   box_half[2] = val[CW-2:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_box(int cx, int cy, int cz, int hx, int hy, int hz);
        write_reg(REG_CENTER_X, cx[CW-1:0]);
        write_reg(REG_CENTER_Y, cy[CW-1:0]);
        write_reg(REG_CENTER_Z, cz[CW-1:0]);
        write_reg(REG_HALF_X, hx[CW-1:0]);
        write_reg(REG_HALF_Y, hy[CW-1:0]);
        write_reg(REG_HALF_Z, hz[CW-1:0]);
    endtask

    // Vertices scattered around the box, or anywhere in the field.
    function automatic tri_t random_triangle();
        tri_t t;
        longint span, off;
        int k;
        bit wide;
        wide = ($urandom_range(99) < 25);
        for (int i = 0; i < 9; i++)
        begin
            k = i % 3;
            if (wide)
                t[i] = $urandom;
            else
            begin
                span = 2 * longint'(box_half[k]) + $urandom_range(2048);
                off  = longint'($urandom_range(0, 2 * span)) - span;
                t[i] = int'(longint'(sext(box_ctr[k])) + off);
            end
        end
        return t;
    endfunction

    task automatic test_directed();
        tri_t t;
        // Reset box is a point at the origin.
        t = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                                send_triangle(t);
        t = '{-256, 0, 0, 256, 0, 0, 0, 256, 0};                         send_triangle(t);
        t = '{256, 256, 256, 512, 256, 256, 256, 512, 256};              send_triangle(t);
        drain();
        set_box(0, 0, 0, 1024, 1024, 1024);
        // Touching the face x = +half counts as overlap.
        t = '{1024, 0, 0, 2048, 0, 0, 2048, 512, 0};                     send_triangle(t);
        t = '{1025, 0, 0, 2048, 0, 0, 2048, 512, 0};                     send_triangle(t);
        // Degenerate: all three vertices equal, inside and outside.
        t = '{10, 20, 30, 10, 20, 30, 10, 20, 30};                       send_triangle(t);
        t = '{5000, 20, 30, 5000, 20, 30, 5000, 20, 30};                 send_triangle(t);
        // Zero-length edge, and an edge parallel to a box axis.
        t = '{0, 3000, 0, 0, 3000, 0, 100, 3000, 100};                   send_triangle(t);
        t = '{-3000, 500, 500, 3000, 500, 500, 0, 600, 2000};            send_triangle(t);
        // Large triangle enclosing the box's slab but missing by a diagonal edge.
        t = '{2000, 2000, -5000, 2000, 2000, 5000, 5000, -1000, 0};      send_triangle(t);
        t = '{1500, 1500, 1500, -8000, 3000, 0, 3000, -8000, 0};         send_triangle(t);
        // Field extremes.
        t = '{8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
              8388607, 8388607, 8388607};                                send_triangle(t);
        t = '{-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
              -8388608, 8388607, -8388608};                              send_triangle(t);
        drain();
        // Extreme box: corner center, maximum extents; flat box with zero half z.
        set_box(-8388608, 8388607, -8388608, 8388607, 8388607, 8388607);
        t = '{8388607, -8388608, 8388607, -8388608, 8388607, -8388608,
              0, 0, 0};                                                  send_triangle(t);
        t = '{-1, -1, -1, 0, 0, 0, 1, 1, 1};                             send_triangle(t);
        drain();
        set_box(0, 0, 0, 4096, 4096, 0);
        t = '{0, 0, 1, 100, 0, 1, 0, 100, 1};                            send_triangle(t);
        t = '{0, 0, 1, 100, 0, -1, 0, 100, 1};                           send_triangle(t);
        drain();
        // Spare addresses are dropped; the box must stay as it is.
        write_reg(REG_SPARE_6, 24'hFFFFFF);
        write_reg(REG_SPARE_7, 24'h123456);
        // Bit 23 of a half-extent write is masked off.
        write_reg(REG_HALF_Z, 24'h800100);
        t = '{0, 0, 200, 100, 0, 200, 0, 100, 200};                      send_triangle(t);
        t = '{0, 0, 300, 100, 0, 300, 0, 100, 300};                      send_triangle(t);
        drain();
    endtask

    task automatic run_random_phase(int n_items);
        set_box($urandom, $urandom, $urandom,
                $urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
        for (int i = 0; i < n_items; i++)
        begin
            // One random triangle per item, with the phase's source and sink idle rates.
            send_triangle(random_triangle());
        end
        drain();
    endtask

    task automatic test_random();
        src_idle_pct = 20; sink_idle_pct = 65;
        for (int p = 0; p < 3; p++) run_random_phase(165);
        src_idle_pct = 65; sink_idle_pct = 20;
        for (int p = 0; p < 3; p++) run_random_phase(165);
        src_idle_pct = 0; sink_idle_pct = 0;
        for (int p = 0; p < 3; p++) run_random_phase(165);
        // Large extents near the field edge.
        set_box(8388607, -8388608, 0, 8388607, 4194304, 1);
        for (int i = 0; i < 40; i++) send_triangle(random_triangle());
        drain();
    endtask

    task automatic test_backpressure();
        src_idle_pct = 0; sink_idle_pct = 0;
        set_box(0, 0, 0, 20000, 20000, 20000);
        sink_holdoff = 300;
        for (int i = 0; i < 60; i++) send_triangle(random_triangle());
        // Hold the source until everything is back, then resume.
        drain();
        sink_idle_pct = 30;
        for (int i = 0; i < 40; i++) send_triangle(random_triangle());
        drain();
    endtask

    initial
    begin
        err_cnt       = 0;
        cyc_cnt       = 0;
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        sink_holdoff  = 0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = REG_CENTER_X;
        cfg_wdata     = '0;
        for (int k = 0; k < 3; k++)
        begin
            box_ctr[k]  = '0;
            box_half[k] = '0;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random();
        test_backpressure();

        if (err_cnt == 0)
            $display("PASS box_triangle_overlap_sat");
        else
            $display("FAIL box_triangle_overlap_sat");
        $finish;
    end

endmodule
